// ===== rtl/mrsw_pkg.sv =====
// ----------------------------------------------------------------------------
// mrsw_pkg
// Shared types and constants for the single-witness Miller-Rabin tester.
// ----------------------------------------------------------------------------
package mrsw_pkg;

  // Default datapath width and the fixed width of the input fields.
  localparam int MRSW_WIDTH = 32;
  localparam int IN_W       = 32;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCREEN,
    S_RED,
    S_RED_WAIT,
    S_TZ,
    S_POW,
    S_MUL_R_WAIT,
    S_MUL_B,
    S_MUL_B_WAIT,
    S_TEST,
    S_SQ_CHK,
    S_SQ_WAIT,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic red_start;
    logic red_take;
    logic tz_shift;
    logic mul_r_start;
    logic mul_b_start;
    logic mul_sq_start;
    logic take_r;
    logic take_b;
    logic set_verdict;
    logic verdict_val;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_lt2;
    logic n_gt5;
    logic n_even;
    logic n_mul5;
    logic rem_done;
    logic q_odd;
    logic e_zero;
    logic e_lsb;
    logic mul_done;
    logic r_is_one;
    logic r_is_nm1;
    logic k_zero;
  } status_t;

endpackage

// ===== rtl/mrsw_rem.sv =====
// ----------------------------------------------------------------------------
// mrsw_rem
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mrsw_rem import mrsw_pkg::*; #(
  parameter int WIDTH = MRSW_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] rem
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] dv;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH:0]   r_ext;
  logic [WIDTH:0]   diff;

  always_comb begin
    r_ext = {rem, dv[WIDTH-1]};
    diff  = r_ext - {1'b0, dvs};
    // For a nonzero divisor, the partial remainder always stays below it.
    if (r_ext >= {1'b0, dvs}) begin
      rem_next = diff[WIDTH-1:0];
    end else begin
      rem_next = r_ext[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dv   <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        dv  <= dv << 1;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/mrsw_mulmod.sv =====
// ----------------------------------------------------------------------------
// mrsw_mulmod
// Iterative modular multiplier by shift-and-add, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module mrsw_mulmod import mrsw_pkg::*; #(
  parameter int WIDTH = MRSW_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] product
);

  logic             busy;
  logic [WIDTH-1:0] xx;
  logic [WIDTH-1:0] yy;
  logic [WIDTH-1:0] mm;
  logic [WIDTH-1:0] room;
  logic [WIDTH-1:0] acc_next;
  logic [WIDTH-1:0] xx_next;

  // Both operands are below the modulus, so each sum either stays below it
  // or needs one subtraction, taken here as a compare against m - xx.
  always_comb begin
    room = mm - xx;
    if (product >= room) begin
      acc_next = product - room;
    end else begin
      acc_next = product + xx;
    end
    if (xx >= room) begin
      xx_next = xx - room;
    end else begin
      xx_next = xx + xx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        product <= '0;
        xx      <= x;
        yy      <= y;
        mm      <= m;
      end else if (busy) begin
        if (yy == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (yy[0]) begin
            product <= acc_next;
          end
          xx <= xx_next;
          yy <= yy >> 1;
        end
      end
    end
  end

endmodule

// ===== rtl/mrsw_datapath.sv =====
// ----------------------------------------------------------------------------
// mrsw_datapath
// Operand registers, exponent and square counters, remainder and multiplier.
// ----------------------------------------------------------------------------
module mrsw_datapath import mrsw_pkg::*; #(
  parameter int WIDTH = MRSW_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  input  cmd_t            cmd,
  input  logic [IN_W-1:0] witness,
  input  logic [IN_W-1:0] number_to_test,
  output status_t         status,
  output logic            verdict
);

  localparam int KW = $clog2(WIDTH);

  logic [63:0]      wit_ext;
  logic [63:0]      num_ext;
  logic [WIDTH-1:0] n_in;
  logic [WIDTH-1:0] n;
  logic [WIDTH-1:0] nm1;
  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] e;
  logic [WIDTH-1:0] r;
  logic [KW-1:0]    k;

  logic [63:0]      n_wide;
  logic [32:0]      f32;
  logic [17:0]      f16;
  logic [10:0]      f8;
  logic [7:0]       f4a;
  logic [4:0]       f4b;
  logic [4:0]       f4c;

  logic             rem_start;
  logic [WIDTH-1:0] rem_dividend;
  logic [WIDTH-1:0] rem_divisor;
  logic             rem_done;
  logic [WIDTH-1:0] rem_val;

  logic             mul_start;
  logic [WIDTH-1:0] mul_x;
  logic [WIDTH-1:0] mul_y;
  logic             mul_done;
  logic [WIDTH-1:0] mul_p;

  // Input bits above the datapath width are dropped; narrower inputs are
  // zero extended.
  assign wit_ext = {32'd0, witness};
  assign num_ext = {32'd0, number_to_test};
  assign n_in    = num_ext[WIDTH-1:0];

  // Since 2^4, 2^8, 2^16 and 2^32 are all 1 modulo 5, folding the halves
  // of n onto each other keeps its residue; the last fold is at most 15.
  assign n_wide = 64'(n);
  assign f32    = {1'b0, n_wide[63:32]} + {1'b0, n_wide[31:0]};
  assign f16    = {1'b0, f32[32:16]} + {2'b0, f32[15:0]};
  assign f8     = {1'b0, f16[17:8]} + {3'b0, f16[7:0]};
  assign f4a    = {1'b0, f8[10:4]} + {4'b0, f8[3:0]};
  assign f4b    = {1'b0, f4a[7:4]} + {1'b0, f4a[3:0]};
  assign f4c    = {4'b0, f4b[4]} + {1'b0, f4b[3:0]};

  assign rem_start    = cmd.red_start;
  assign rem_dividend = a;
  assign rem_divisor  = n;

  assign mul_start = cmd.mul_r_start | cmd.mul_b_start | cmd.mul_sq_start;

  always_comb begin
    mul_x = r;
    mul_y = r;
    if (cmd.mul_r_start) begin
      mul_y = base;
    end else if (cmd.mul_b_start) begin
      mul_x = base;
      mul_y = base;
    end
  end

  mrsw_rem #(.WIDTH(WIDTH)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .done     (rem_done),
    .rem      (rem_val)
  );

  mrsw_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x       (mul_x),
    .y       (mul_y),
    .m       (n),
    .done    (mul_done),
    .product (mul_p)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a   <= wit_ext[WIDTH-1:0];
      n   <= n_in;
      nm1 <= n_in - WIDTH'(1);
      e   <= n_in - WIDTH'(1);
      k   <= '0;
      r   <= WIDTH'(1);
    end
    if (cmd.red_take) begin
      base <= rem_val;
    end
    if (cmd.tz_shift) begin
      e <= e >> 1;
      k <= k + KW'(1);
    end
    if (cmd.take_r) begin
      r <= mul_p;
    end
    if (cmd.take_b) begin
      base <= mul_p;
      e    <= e >> 1;
    end
    if (cmd.mul_sq_start) begin
      k <= k - KW'(1);
    end
    if (cmd.set_verdict) begin
      verdict <= cmd.verdict_val;
    end
  end

  assign status.n_lt2    = (n < WIDTH'(2));
  assign status.n_gt5    = (n > WIDTH'(5));
  assign status.n_even   = ~n[0];
  assign status.n_mul5   = (f4c inside {5'd0, 5'd5, 5'd10, 5'd15});
  assign status.rem_done = rem_done;
  assign status.q_odd    = e[0];
  assign status.e_zero   = (e == '0);
  assign status.e_lsb    = e[0];
  assign status.mul_done = mul_done;
  assign status.r_is_one = (r == WIDTH'(1));
  assign status.r_is_nm1 = (r == nm1);
  assign status.k_zero   = (k == '0);

endmodule

// ===== rtl/mrsw_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrsw_ctrl
// Sequencer for screening, reduction, exponentiation and squaring steps.
// ----------------------------------------------------------------------------
module mrsw_ctrl import mrsw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_SCREEN;
      end
      S_SCREEN: begin
        if (status.n_lt2) begin
          state_next = S_DONE;
        end else if (status.n_gt5 && (status.n_even || status.n_mul5)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RED;
        end
      end
      S_RED:       state_next = S_RED_WAIT;
      S_RED_WAIT: begin
        if (status.rem_done) state_next = S_TZ;
      end
      S_TZ: begin
        if (status.q_odd) state_next = S_POW;
      end
      S_POW: begin
        if (status.e_zero) begin
          state_next = S_TEST;
        end else if (status.e_lsb) begin
          state_next = S_MUL_R_WAIT;
        end else begin
          state_next = S_MUL_B;
        end
      end
      S_MUL_R_WAIT: begin
        if (status.mul_done) state_next = S_MUL_B;
      end
      S_MUL_B:      state_next = S_MUL_B_WAIT;
      S_MUL_B_WAIT: begin
        if (status.mul_done) state_next = S_POW;
      end
      S_TEST: begin
        state_next = status.r_is_one ? S_DONE : S_SQ_CHK;
      end
      S_SQ_CHK: begin
        if (status.k_zero || status.r_is_nm1) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SQ_WAIT;
        end
      end
      S_SQ_WAIT: begin
        if (status.mul_done) state_next = S_SQ_CHK;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    done = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_SCREEN: begin
        if (status.n_lt2 || (status.n_gt5 && (status.n_even || status.n_mul5))) begin
          cmd.set_verdict = 1'b1;
        end
      end
      S_RED: begin
        cmd.red_start = 1'b1;
      end
      S_RED_WAIT: begin
        cmd.red_take = status.rem_done;
      end
      S_TZ: begin
        cmd.tz_shift = ~status.q_odd;
      end
      S_POW: begin
        cmd.mul_r_start = ~status.e_zero & status.e_lsb;
      end
      S_MUL_R_WAIT: begin
        cmd.take_r = status.mul_done;
      end
      S_MUL_B: begin
        cmd.mul_b_start = 1'b1;
      end
      S_MUL_B_WAIT: begin
        cmd.take_b = status.mul_done;
      end
      S_TEST: begin
        if (status.r_is_one) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict_val = 1'b1;
        end
      end
      S_SQ_CHK: begin
        if (status.k_zero) begin
          cmd.set_verdict = 1'b1;
        end else if (status.r_is_nm1) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict_val = 1'b1;
        end else begin
          cmd.mul_sq_start = 1'b1;
        end
      end
      S_SQ_WAIT: begin
        cmd.take_r = status.mul_done;
      end
      S_DONE: begin
        done = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/miller_rabin_single_witness.sv =====
// ----------------------------------------------------------------------------
// miller_rabin_single_witness
// Single-witness Miller-Rabin primality test with a one-bit verdict.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Handshake
//  --------  -------------------------------  --------------------------------
//  request   witness, number_to_test          beat taken when start & !busy
//  result    verdict                          beat valid for one cycle on done
//
// The run time grows with b, the bit length of the odd part of n-1, and
// with k, its count of trailing zeros; it is set mostly by the shared
// shift-and-add modular multiplier, which works through the multiplier
// bits one at a time. Screens for n below two and for even n or multiples
// of five above five end a test straight from the screening state into the
// done state. Reset is synchronous and returns the sequencer to idle. The
// receiver cannot stall: the verdict is shown for one cycle with done, and
// busy stays high from the accepted beat until that cycle.
//
module miller_rabin_single_witness import mrsw_pkg::*; #(
  parameter int WIDTH = MRSW_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [IN_W-1:0] witness,
  input  logic [IN_W-1:0] number_to_test,
  output logic            done,
  output logic            verdict
);

  // Commands from the sequencer and status back from the datapath.
  cmd_t    cmd;
  status_t status;

  // The sequencer walks through the screens, the reduction of the witness
  // modulo n, the trailing-zero count of n-1, the square-and-multiply loop
  // and finally the chain of squarings that looks for n-1.
  mrsw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // The datapath holds the operands, the remainder unit and the shared modular
  // multiplier; the verdict register is written once per test.
  mrsw_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .witness        (witness),
    .number_to_test (number_to_test),
    .status         (status),
    .verdict        (verdict)
  );

endmodule
